// ===== rtl/core/aesrt_pkg.sv =====
// aesrt_pkg: shared types, constants, s-box tables and gf(2^8) helpers for the aes round unit
package aesrt_pkg;

  // beat widths
  localparam int unsigned BlockW  = 128;
  localparam int unsigned InDataW = 256;
  localparam int unsigned InUserW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned Bytes   = BlockW / 8;
  localparam int unsigned ProdW   = 15;

  // reduction polynomial x^8 + x^4 + x^3 + x + 1
  localparam logic [8:0] GfPoly = 9'h11B;

  // transform selector carried in tuser
  typedef enum logic [1:0] {
    ACT_SUB_BYTES  = 2'd0,
    ACT_SHIFT_ROWS = 2'd1,
    ACT_MIX_COLS   = 2'd2,
    ACT_ADD_KEY    = 2'd3
  } action_e;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MIX_ROW0 = 2'd0,
    REG_MIX_ROW1 = 2'd1,
    REG_MIX_ROW2 = 2'd2,
    REG_MIX_ROW3 = 2'd3
  } reg_idx_e;

  // mix matrix reset rows, column 0 in the top byte
  localparam logic [CfgW-1:0] MixRow0Rst = 32'h0203_0101;
  localparam logic [CfgW-1:0] MixRow1Rst = 32'h0102_0301;
  localparam logic [CfgW-1:0] MixRow2Rst = 32'h0101_0203;
  localparam logic [CfgW-1:0] MixRow3Rst = 32'h0301_0102;

  // forward s-box
  localparam logic [7:0] FwdSbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // inverse s-box
  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // carry-less 8x8 product, not yet reduced
  function automatic logic [ProdW-1:0] clmul8(logic [7:0] a, logic [7:0] b);
    logic [ProdW-1:0] p;
    p = '0;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) begin
        p = p ^ (ProdW'(a) << n);
      end
    end
    return p;
  endfunction

  // fold the upper seven bits back with the field polynomial
  function automatic logic [7:0] gf_reduce(logic [ProdW-1:0] p_in);
    logic [ProdW-1:0] p;
    p = p_in;
    for (int k = ProdW - 1; k >= 8; k--) begin
      if (p[k]) begin
        p = p ^ (ProdW'(GfPoly) << (k - 8));
      end
    end
    return p[7:0];
  endfunction

endpackage

// ===== rtl/core/aes_round_transform_unit_core.sv =====
// aes_round_transform_unit_core: three-stage pipelined aes round transform with apb matrix registers
//
// channel  | dir | beat contents
// s_axis   | in  | tdata: state_hi, state_lo, key_hi, key_lo; tuser: action, direction
// m_axis   | out | tdata: result_hi, result_lo
// apb      | in  | mix_row_zero..mix_row_three at byte addresses 0, 4, 8, 12
//
// one beat accepted per cycle unless a stall on m_axis backs up to the input; a result passes
// through the stages in order: table lookups and carry-less products, column xor, field reduction
// and selection into the output register
// stalls on m_axis hold each stage in place; a stage refills as soon as it empties
// rst_ni clears the valid bits and loads the standard mix matrix
module aes_round_transform_unit_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [63:0] state_hi, [127:64] state_lo, [191:128] key_hi, [255:192] key_lo
  input  logic [aesrt_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] action, [2] direction
  input  logic [aesrt_pkg::InUserW-1:0]  s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [63:0] result_hi, [127:64] result_lo
  output logic [aesrt_pkg::BlockW-1:0]   m_axis_tdata,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aesrt_pkg::AddrW-1:0]    paddr,
  input  logic [aesrt_pkg::CfgW-1:0]     pwdata,
  output logic [aesrt_pkg::CfgW-1:0]     prdata,
  output logic                           pready
);
  import aesrt_pkg::*;

  // matrix row registers
  logic [CfgW-1:0] mix_row_q [4];
  logic [CfgW-1:0] mix_row_d [4];
  reg_idx_e        reg_idx;
  logic            cfg_wr;

  // pipeline control
  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3;

  // stage payloads
  logic [BlockW-1:0] plain1_q, plain1_d;
  logic              mix1_q, mix1_d;
  logic [ProdW-1:0]  prod1_q [Bytes*4];
  logic [ProdW-1:0]  prod1_d [Bytes*4];
  logic [BlockW-1:0] plain2_q;
  logic              mix2_q;
  logic [ProdW-1:0]  sum2_q [Bytes];
  logic [ProdW-1:0]  sum2_d [Bytes];
  logic [BlockW-1:0] out3_q, out3_d;

  // input beat unpacked, row 0 column 0 in the top byte
  logic [BlockW-1:0] state_w;
  logic [BlockW-1:0] key_w;
  action_e           action_w;
  logic              inverse_w;

  assign state_w   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign key_w     = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
  assign action_w  = action_e'(s_axis_tuser[1:0]);
  assign inverse_w = s_axis_tuser[2];

  // apb access, word index from paddr[3:2]
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_MIX_ROW0: prdata = mix_row_q[0];
      REG_MIX_ROW1: prdata = mix_row_q[1];
      REG_MIX_ROW2: prdata = mix_row_q[2];
      REG_MIX_ROW3: prdata = mix_row_q[3];
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mix_row_d[r] = mix_row_q[r];
    end
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIX_ROW0: mix_row_d[0] = pwdata;
        REG_MIX_ROW1: mix_row_d[1] = pwdata;
        REG_MIX_ROW2: mix_row_d[2] = pwdata;
        REG_MIX_ROW3: mix_row_d[3] = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_row_q[0] <= MixRow0Rst;
      mix_row_q[1] <= MixRow1Rst;
      mix_row_q[2] <= MixRow2Rst;
      mix_row_q[3] <= MixRow3Rst;
    end else begin
      for (int r = 0; r < 4; r++) begin
        mix_row_q[r] <= mix_row_d[r];
      end
    end
  end

  // handshake chain: a stage takes a beat when it is empty or passes its own on
  assign ready3        = !v3_q || m_axis_tready;
  assign ready2        = !v2_q || ready3;
  assign ready1        = !v1_q || ready2;
  assign s_axis_tready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= s_axis_tvalid;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage 1: s-box, row shift and key xor; carry-less products for the mix
  always_comb begin
    logic [1:0] src;
    logic [7:0] sb;
    plain1_d = '0;
    mix1_d   = (action_w == ACT_MIX_COLS);
    src      = '0;
    sb       = '0;
    for (int k = 0; k < 16; k++) begin
      sb = state_w[8*(15-k) +: 8];
      case (action_w)
        ACT_SUB_BYTES: begin
          plain1_d[8*(15-k) +: 8] = inverse_w ? InvSbox[sb] : FwdSbox[sb];
        end
        ACT_SHIFT_ROWS: begin
          src = inverse_w ? 2'((k & 3) - (k >> 2)) : 2'((k & 3) + (k >> 2));
          plain1_d[8*(15-k) +: 8] = state_w[8*(15 - 4*(k >> 2) - int'(src)) +: 8];
        end
        ACT_ADD_KEY: begin
          plain1_d[8*(15-k) +: 8] = sb ^ key_w[8*(15-k) +: 8];
        end
        default: ;
      endcase
    end
    // product of row i coefficient t with state byte (t, j)
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int t = 0; t < 4; t++) begin
          prod1_d[16*i + 4*j + t] = clmul8(mix_row_q[i][8*(3-t) +: 8],
                                           state_w[8*(15 - 4*t - j) +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && s_axis_tvalid) begin
      plain1_q <= plain1_d;
      mix1_q   <= mix1_d;
      prod1_q  <= prod1_d;
    end
  end

  // stage 2: xor the four products of each output byte
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sum2_d[k] = prod1_q[4*k] ^ prod1_q[4*k+1] ^ prod1_q[4*k+2] ^ prod1_q[4*k+3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      plain2_q <= plain1_q;
      mix2_q   <= mix1_q;
      sum2_q   <= sum2_d;
    end
  end

  // stage 3: field reduction and result select
  always_comb begin
    out3_d = plain2_q;
    if (mix2_q) begin
      for (int k = 0; k < 16; k++) begin
        out3_d[8*(15-k) +: 8] = gf_reduce(sum2_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q) begin
      out3_q <= out3_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {out3_q[63:0], out3_q[127:64]};

  // an accepted beat always lands in stage 1
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted beat did not reach stage 1");

  // an empty first stage never refuses a beat
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("stage 1 empty but input not ready");

  // a stalled stage 2 beat stays put
  a_hold_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !ready3 |=> v2_q && $stable(plain2_q) && $stable(mix2_q))
    else $error("stage 2 beat lost under stall");

  // a stalled stage 1 beat stays put
  a_hold_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !ready2 |=> v1_q && $stable(plain1_q) && $stable(mix1_q))
    else $error("stage 1 beat lost under stall");

endmodule
